### sv/sraef_pkg.sv
// ----------------------------------------------------------------------------
// sraef_pkg
// Shared widths, reset values, register indexes and state codes of the
// spike-rejecting adaptive EMA filter.
// ----------------------------------------------------------------------------
package sraef_pkg;

  localparam int LevelW     = 14;
  localparam int AlphaW     = 9;
  localparam int CountW     = 32;
  localparam int ProdW      = LevelW + AlphaW;
  localparam int WindowSize = 5;
  localparam int CfgIdxW    = 2;
  localparam int InTdataW   = 16;
  localparam int OutTdataW  = 4 * LevelW + CountW;

  localparam logic [LevelW-1:0] SpikeThrRst = LevelW'(2400);
  localparam logic [LevelW-1:0] FastThrRst  = LevelW'(480);
  localparam logic [AlphaW-1:0] AlphaFastRst = AlphaW'(128);
  localparam logic [AlphaW-1:0] AlphaSlowRst = AlphaW'(51);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPIKE_THR  = 2'd0,
    CFG_FAST_THR   = 2'd1,
    CFG_ALPHA_FAST = 2'd2,
    CFG_ALPHA_SLOW = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic mul_start;
    logic div_start;
    logic win_push;
    logic load_out;
  } ctrl_t;

endpackage

### sv/sraef_mul.sv
// ----------------------------------------------------------------------------
// sraef_mul
// Bit-serial shift-add multiplier: alpha times distance, one alpha bit per
// cycle, unsigned.
// ----------------------------------------------------------------------------
module sraef_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [sraef_pkg::AlphaW-1:0]       alpha_i,
  input  logic [sraef_pkg::LevelW-1:0]       dist_i,
  output logic                               busy_o,
  output logic [sraef_pkg::ProdW-1:0]        prod_o
);

  localparam int AW   = sraef_pkg::AlphaW;
  localparam int BW   = sraef_pkg::LevelW;
  localparam int PW   = sraef_pkg::ProdW;
  localparam int CntW = $clog2(AW + 1);

  logic [PW-1:0]   p_q, p_d;
  logic [BW-1:0]   b_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [BW:0]     acc;

  always_comb begin
    acc = {1'b0, p_q[PW-1:AW]} + (p_q[0] ? {1'b0, b_q} : '0);
    p_d = {acc, p_q[AW-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q    <= '0;
      b_q    <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      p_q    <= {{BW{1'b0}}, alpha_i};
      b_q    <= dist_i;
      cnt_q  <= CntW'(AW);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      p_q   <= p_d;
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign prod_o = p_q;

endmodule

### sv/sraef_div.sv
// ----------------------------------------------------------------------------
// sraef_div
// Restoring divider, one quotient bit per cycle, for the window mean.
// ----------------------------------------------------------------------------
module sraef_div #(
  parameter int NumW = 17,
  parameter int DenW = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quo_o
);

  localparam int CntW = $clog2(NumW + 1);

  logic [DenW-1:0] rem_q, den_q;
  logic [NumW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic [DenW:0]   shifted, diff;
  logic            fits;

  always_comb begin
    shifted = {rem_q, quo_q[NumW-1]};
    fits    = shifted >= {1'b0, den_q};
    diff    = shifted - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= '0;
      den_q  <= den_i;
      quo_q  <= num_i;
      cnt_q  <= CntW'(NumW);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DenW-1:0] : shifted[DenW-1:0];
      quo_q <= {quo_q[NumW-2:0], fits};
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;

endmodule

### sv/sraef_win.sv
// ----------------------------------------------------------------------------
// sraef_win
// Circular window of accepted samples with running sum and fill count.
// ----------------------------------------------------------------------------
module sraef_win #(
  parameter int WINDOW_SIZE = sraef_pkg::WindowSize
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            push_i,
  input  logic [sraef_pkg::LevelW-1:0]                    sample_i,
  output logic [sraef_pkg::LevelW+$clog2(WINDOW_SIZE+1)-1:0] sum_o,
  output logic [$clog2(WINDOW_SIZE+1)-1:0]                fill_o
);

  localparam int LW    = sraef_pkg::LevelW;
  localparam int FillW = $clog2(WINDOW_SIZE + 1);
  localparam int SumW  = LW + FillW;
  localparam int SlotW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

  logic [LW-1:0]    store_q [WINDOW_SIZE];
  logic [SlotW-1:0] slot_q;
  logic [FillW-1:0] fill_q;
  logic [SumW-1:0]  sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        store_q[i] <= '0;
      end
      slot_q <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else if (push_i) begin
      sum_q           <= sum_q - SumW'(store_q[slot_q]) + SumW'(sample_i);
      store_q[slot_q] <= sample_i;
      slot_q          <= (slot_q == SlotW'(WINDOW_SIZE - 1)) ? '0 : slot_q + 1'b1;
      if (fill_q != FillW'(WINDOW_SIZE)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

### sv/spike_rejecting_adaptive_ema_filter.sv
// ----------------------------------------------------------------------------
// spike_rejecting_adaptive_ema_filter
// Adaptive EMA with spike rejection, min/max tracking and a windowed mean.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per item (tdata[13:0], 4 fraction bits).
//   m_axis returns one result per item: tdata holds filtered level, window
//   mean, min, max and the saturating reject count; tuser is the spike flag.
//   cfg writes a register by index: 0 spike threshold, 1 fast threshold,
//   2 fast alpha, 3 slow alpha. cfg_ready_o is always high; write only
//   while no item is in flight.
//   Steps: an item is taken in the idle state, then decide, start, run (while
//   the serial units work) and done, which loads the output register. One
//   item is in work at a time, so a new item is taken only after the last
//   one is loaded into the output register; the bit-serial divider that forms
//   the mean runs longer than the serial multiplier beside it.
//   The result waits in an output register, so the next item is taken while
//   it is stalled; a further result holds in its last step until m_axis_tready.
//   Reset loads the register defaults, clears the EMA, min, max, counter and
//   window, and the next sample loads the EMA, min and max.
// ----------------------------------------------------------------------------
module spike_rejecting_adaptive_ema_filter #(
  parameter int WINDOW_SIZE = sraef_pkg::WindowSize
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sraef_pkg::InTdataW-1:0]     s_axis_tdata,   // sample
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // filtered_level, window_mean, min_level, max_level, rejected_count
  output logic [sraef_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                               m_axis_tuser,   // spike_flag
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sraef_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [sraef_pkg::LevelW-1:0]       cfg_data_i
);

  localparam int LW    = sraef_pkg::LevelW;
  localparam int AW    = sraef_pkg::AlphaW;
  localparam int CW    = sraef_pkg::CountW;
  localparam int PW    = sraef_pkg::ProdW;
  localparam int FillW = $clog2(WINDOW_SIZE + 1);
  localparam int SumW  = LW + FillW;

  sraef_pkg::state_e state_q, state_d;
  sraef_pkg::ctrl_t  ctrl;

  logic [LW-1:0] spike_thr_q, fast_thr_q;
  logic [AW-1:0] alpha_fast_q, alpha_slow_q, alpha_q;
  logic [LW-1:0] sample_q, ema_q, min_q, max_q, dist_q, dist_abs;
  logic [CW-1:0] rej_q;
  logic          first_q, spike_q, upd_q, neg_q;
  logic          is_neg, is_spike;

  logic [SumW-1:0]  win_sum, quo;
  logic [FillW-1:0] win_fill;
  logic             mul_busy, div_busy;
  logic [PW-1:0]    prod;

  logic [LW:0]   step_up, step_dn;
  logic [LW+1:0] ema_up;
  logic [LW-1:0] ema_new, mean;

  logic          out_valid_q;
  logic [LW-1:0] out_ema_q, out_mean_q, out_min_q, out_max_q;
  logic          out_spike_q;
  logic [CW-1:0] out_rej_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spike_thr_q  <= sraef_pkg::SpikeThrRst;
      fast_thr_q   <= sraef_pkg::FastThrRst;
      alpha_fast_q <= sraef_pkg::AlphaFastRst;
      alpha_slow_q <= sraef_pkg::AlphaSlowRst;
    end else if (cfg_valid_i) begin
      case (sraef_pkg::cfg_reg_e'(cfg_index_i))
        sraef_pkg::CFG_SPIKE_THR:  spike_thr_q  <= cfg_data_i;
        sraef_pkg::CFG_FAST_THR:   fast_thr_q   <= cfg_data_i;
        sraef_pkg::CFG_ALPHA_FAST: alpha_fast_q <= cfg_data_i[AW-1:0];
        sraef_pkg::CFG_ALPHA_SLOW: alpha_slow_q <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // decision on the captured sample
  always_comb begin
    is_neg   = sample_q < ema_q;
    dist_abs = is_neg ? (ema_q - sample_q) : (sample_q - ema_q);
    is_spike = !first_q && (dist_abs > spike_thr_q);
  end

  // EMA step from the serial product: floor toward minus infinity
  always_comb begin
    step_up = prod[PW-1:8];
    step_dn = prod[PW-1:8] + {{LW{1'b0}}, (prod[7:0] != 8'd0)};
    ema_up  = {2'b00, ema_q} + {1'b0, step_up};
    if (neg_q) begin
      ema_new = (step_dn > {1'b0, ema_q}) ? '0 : ema_q - step_dn[LW-1:0];
    end else begin
      ema_new = (ema_up > (LW+2)'({LW{1'b1}})) ? {LW{1'b1}} : ema_up[LW-1:0];
    end
    mean = (win_fill == '0) ? '0 : quo[LW-1:0];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sraef_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl    = '0;
    case (state_q)
      sraef_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = sraef_pkg::ST_DECIDE;
        end
      end
      sraef_pkg::ST_DECIDE: begin
        ctrl.win_push = !is_spike;
        state_d       = sraef_pkg::ST_START;
      end
      sraef_pkg::ST_START: begin
        ctrl.mul_start = 1'b1;
        ctrl.div_start = 1'b1;
        state_d        = sraef_pkg::ST_RUN;
      end
      sraef_pkg::ST_RUN: begin
        if (!mul_busy && !div_busy) begin
          state_d = sraef_pkg::ST_DONE;
        end
      end
      sraef_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          ctrl.load_out = 1'b1;
          state_d       = sraef_pkg::ST_IDLE;
        end
      end
      default: state_d = sraef_pkg::ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == sraef_pkg::ST_IDLE);

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
      ema_q    <= '0;
      min_q    <= '0;
      max_q    <= '0;
      dist_q   <= '0;
      alpha_q  <= '0;
      rej_q    <= '0;
      first_q  <= 1'b1;
      spike_q  <= 1'b0;
      upd_q    <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sample_q <= s_axis_tdata[LW-1:0];
      end
      if (state_q == sraef_pkg::ST_DECIDE) begin
        dist_q  <= dist_abs;
        neg_q   <= is_neg;
        alpha_q <= (dist_abs > fast_thr_q) ? alpha_fast_q : alpha_slow_q;
        if (first_q) begin
          ema_q   <= sample_q;
          min_q   <= sample_q;
          max_q   <= sample_q;
          first_q <= 1'b0;
          upd_q   <= 1'b0;
        end else begin
          if (sample_q < min_q) min_q <= sample_q;
          if (sample_q > max_q) max_q <= sample_q;
          spike_q <= is_spike;
          upd_q   <= !is_spike;
          if (is_spike && (rej_q != {CW{1'b1}})) begin
            rej_q <= rej_q + 1'b1;
          end
        end
      end
      if (ctrl.load_out && upd_q) begin
        ema_q <= ema_new;
      end
    end
  end

  sraef_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.mul_start),
    .alpha_i (alpha_q),
    .dist_i  (dist_q),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  sraef_win #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_win (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (ctrl.win_push),
    .sample_i (sample_q),
    .sum_o    (win_sum),
    .fill_o   (win_fill)
  );

  sraef_div #(
    .NumW (SumW),
    .DenW (FillW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.div_start),
    .num_i   (win_sum),
    .den_i   (win_fill),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_ema_q   <= '0;
      out_mean_q  <= '0;
      out_min_q   <= '0;
      out_max_q   <= '0;
      out_spike_q <= 1'b0;
      out_rej_q   <= '0;
    end else if (ctrl.load_out) begin
      out_valid_q <= 1'b1;
      out_ema_q   <= upd_q ? ema_new : ema_q;
      out_mean_q  <= mean;
      out_min_q   <= min_q;
      out_max_q   <= max_q;
      out_spike_q <= spike_q;
      out_rej_q   <= rej_q;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rej_q, out_max_q, out_min_q, out_mean_q, out_ema_q};
  assign m_axis_tuser  = out_spike_q;

`ifndef NO_ASSERTIONS
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !first_q |-> (min_q <= max_q))
    else $error("min above max");

  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!first_q && state_q != sraef_pkg::ST_DECIDE) |-> (win_fill != '0))
    else $error("empty window after first sample");

  a_rej_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (rej_q >= $past(rej_q)))
    else $error("reject count decreased");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |=> out_valid_q)
    else $error("result lost at output register");

  a_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sraef_pkg::ST_DONE) |-> (!mul_busy && !div_busy))
    else $error("serial unit busy at result");
`endif

endmodule

### tb/spike_rejecting_adaptive_ema_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_rejecting_adaptive_ema_filter_test
// Streams particulate samples through the filter under several register
// settings and idle patterns. A built-in predictor tracks EMA, window mean,
// min/max and the reject count, and every result is checked field by field.
// ----------------------------------------------------------------------------
module spike_rejecting_adaptive_ema_filter_test;

  localparam int LevelW     = sraef_pkg::LevelW;
  localparam int AlphaW     = sraef_pkg::AlphaW;
  localparam int CountW     = sraef_pkg::CountW;
  localparam int WindowSize = sraef_pkg::WindowSize;
  localparam int CfgIdxW    = sraef_pkg::CfgIdxW;
  localparam int InTdataW   = sraef_pkg::InTdataW;
  localparam int OutTdataW  = sraef_pkg::OutTdataW;

  typedef struct {
    logic [LevelW-1:0] filtered;
    logic [LevelW-1:0] mean;
    logic [LevelW-1:0] floor_lvl;
    logic [LevelW-1:0] peak_lvl;
    logic              spike;
    logic [CountW-1:0] rejects;
  } level_report_t;

  class spike_ema_checker;
    logic [LevelW-1:0] spike_thr  = sraef_pkg::SpikeThrRst;
    logic [LevelW-1:0] fast_thr   = sraef_pkg::FastThrRst;
    logic [AlphaW-1:0] alpha_fast = sraef_pkg::AlphaFastRst;
    logic [AlphaW-1:0] alpha_slow = sraef_pkg::AlphaSlowRst;

    logic [LevelW-1:0] ema = '0;
    bit                first_pending = 1'b1;
    logic [LevelW-1:0] window_vals [WindowSize] = '{default: '0};
    int                write_slot = 0;
    int                fill = 0;
    int                window_sum = 0;
    logic [LevelW-1:0] floor_seen = '0;
    logic [LevelW-1:0] peak_seen = '0;
    logic [CountW-1:0] reject_total = '0;
    logic              spike_state = 1'b0;
    int                failures = 0;
    level_report_t     expected_reports [$];

    function void set_register(sraef_pkg::cfg_reg_e idx, logic [LevelW-1:0] value);
      case (idx)
        sraef_pkg::CFG_SPIKE_THR:  spike_thr  = value;
        sraef_pkg::CFG_FAST_THR:   fast_thr   = value;
        sraef_pkg::CFG_ALPHA_FAST: alpha_fast = value[AlphaW-1:0];
        sraef_pkg::CFG_ALPHA_SLOW: alpha_slow = value[AlphaW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [LevelW-1:0] s);
      level_report_t     r;
      logic [LevelW-1:0] distance;
      logic [AlphaW-1:0] alpha;
      longint            prod;
      longint            nxt;
      bit                enter_window;
      enter_window = 1'b0;
      if (first_pending) begin
        ema = s;
        floor_seen = s;
        peak_seen = s;
        first_pending = 1'b0;
        enter_window = 1'b1;
      end else begin
        if (s < floor_seen) floor_seen = s;
        if (s > peak_seen) peak_seen = s;
        distance = (s > ema) ? s - ema : ema - s;
        if (distance > spike_thr) begin
          if (reject_total != '1) reject_total++;
          spike_state = 1'b1;
        end else begin
          alpha = (distance > fast_thr) ? alpha_fast : alpha_slow;
          spike_state = 1'b0;
          prod = longint'(alpha) * (longint'(s) - longint'(ema));
          nxt = longint'(ema) + (prod >>> 8);
          if (nxt < 0) nxt = 0;
          if (nxt > 16383) nxt = 16383;
          ema = LevelW'(nxt);
          enter_window = 1'b1;
        end
      end
      if (enter_window) begin
        window_sum = window_sum - int'(window_vals[write_slot]) + int'(s);
        window_vals[write_slot] = s;
        write_slot = (write_slot + 1) % WindowSize;
        if (fill < WindowSize) fill++;
      end
      r.filtered  = ema;
      r.mean      = (fill != 0) ? LevelW'(window_sum / fill) : '0;
      r.floor_lvl = floor_seen;
      r.peak_lvl  = peak_seen;
      r.spike     = spike_state;
      r.rejects   = reject_total;
      expected_reports.push_back(r);
    endfunction

    function void check_result(logic [OutTdataW-1:0] data, logic flag);
      level_report_t e;
      if (expected_reports.size() == 0) begin
        $error("unexpected result item: tdata=%h tuser=%b", data, flag);
        failures++;
        return;
      end
      e = expected_reports.pop_front();
      if (data[LevelW-1:0] !== e.filtered) begin
        $error("filtered_level: expected %0d, got %0d", e.filtered, data[LevelW-1:0]);
        failures++;
      end
      if (data[2*LevelW-1:LevelW] !== e.mean) begin
        $error("window_mean: expected %0d, got %0d", e.mean, data[2*LevelW-1:LevelW]);
        failures++;
      end
      if (data[3*LevelW-1:2*LevelW] !== e.floor_lvl) begin
        $error("min_level: expected %0d, got %0d", e.floor_lvl, data[3*LevelW-1:2*LevelW]);
        failures++;
      end
      if (data[4*LevelW-1:3*LevelW] !== e.peak_lvl) begin
        $error("max_level: expected %0d, got %0d", e.peak_lvl, data[4*LevelW-1:3*LevelW]);
        failures++;
      end
      if (flag !== e.spike) begin
        $error("spike_flag: expected %0d, got %0d", e.spike, flag);
        failures++;
      end
      if (data[4*LevelW +: CountW] !== e.rejects) begin
        $error("rejected_count: expected %0d, got %0d", e.rejects, data[4*LevelW +: CountW]);
        failures++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [LevelW-1:0]    cfg_data_i = '0;

  spike_ema_checker chk;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_left = 0;

  spike_rejecting_adaptive_ema_filter u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1500000;
    $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, occasionally a long one
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chk.check_result(m_axis_tdata, m_axis_tuser);
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
      if ($urandom_range(9) == 0) stall_left = $urandom_range(20, 50);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic push_sample(input logic [LevelW-1:0] s);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InTdataW-LevelW){1'b0}}, s};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    chk.note_sample(s);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (chk.expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_settings(input int spike, input int fast, input int af, input int asl);
    sraef_pkg::cfg_reg_e order [4] = '{sraef_pkg::CFG_SPIKE_THR, sraef_pkg::CFG_FAST_THR,
                                       sraef_pkg::CFG_ALPHA_FAST, sraef_pkg::CFG_ALPHA_SLOW};
    logic [LevelW-1:0] vals [4];
    vals = '{LevelW'(spike), LevelW'(fast), LevelW'(af), LevelW'(asl)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      chk.set_register(order[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_burst(input int count);
    int roll;
    int spread;
    int s;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        spread = $urandom_range(0, chk.fast_thr);
      end else if (roll < 65) begin
        spread = $urandom_range(chk.fast_thr, chk.spike_thr);
      end else if (roll < 80) begin
        spread = int'($urandom_range(1) ? chk.spike_thr : chk.fast_thr)
                 + int'($urandom_range(2)) - 1;
      end else if (roll < 92) begin
        spread = -1;
      end else begin
        spread = int'(chk.spike_thr) + 1 + int'($urandom_range(0, 2000));
      end
      if (spread < 0) begin
        s = $urandom_range(0, 16383);
      end else begin
        s = $urandom_range(1) ? int'(chk.ema) + spread : int'(chk.ema) - spread;
      end
      if (s < 0) s = 0;
      if (s > 16383) s = 16383;
      push_sample(LevelW'(s));
    end
    drain();
  endtask

  initial begin
    chk = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: first load, threshold edges, extreme spikes, window wrap
    push_sample(LevelW'(8000));
    push_sample(LevelW'(10401));
    push_sample(LevelW'(5599));
    push_sample(LevelW'(10400));
    push_sample(chk.ema + LevelW'(480));
    push_sample(chk.ema + LevelW'(481));
    push_sample(chk.ema - LevelW'(481));
    push_sample(chk.ema - LevelW'(480));
    push_sample(chk.ema);
    push_sample('0);
    push_sample('1);
    push_sample(chk.ema + LevelW'(37));
    push_sample(chk.ema - LevelW'(90));
    push_sample(chk.ema + LevelW'(5));
    push_sample(chk.ema - LevelW'(1));
    drain();

    // alpha above unity saturates both ways, zero alpha holds the EMA
    load_settings(16383, 0, 511, 0);
    push_sample('1);
    push_sample('0);
    push_sample(chk.ema);
    push_sample('1);
    push_sample('0);
    push_sample('1);
    drain();

    for (int k = 0; k < 12; k++) begin
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      case (k)
        0: load_settings(2400, 480, 128, 51);
        1: load_settings(16383, 0, 511, 0);
        2: load_settings(0, 0, 256, 256);
        3: load_settings(16383, 16383, 0, 256);
        default: begin
          load_settings($urandom_range(0, 4000), $urandom_range(0, 3000),
                        ($urandom_range(0, 31) << 9) | $urandom_range(0, 256),
                        ($urandom_range(0, 31) << 9) | $urandom_range(0, 256));
        end
      endcase
      run_burst(120);
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (chk.failures == 0 && chk.expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
